FILE: rtl/opoc_pkg.sv
package opoc_pkg;

    // Tour geometry.
    localparam int TOUR_LENGTH = 8;
    localparam int POS_W       = (TOUR_LENGTH > 1) ? $clog2(TOUR_LENGTH) : 1;
    localparam int CITY_W      = 3;

    localparam logic [POS_W-1:0] LAST_POS  = POS_W'(TOUR_LENGTH - 1);
    localparam logic [POS_W-1:0] FIRST_POS = '0;

    // One input transaction: one position of both parents.
    typedef struct packed {
        logic [CITY_W-1:0] parent1_city;
        logic [CITY_W-1:0] parent2_city;
        logic [CITY_W-1:0] cut_point;
    } t_in_item;

    // One output transaction: one position of the child.
    typedef struct packed {
        logic [CITY_W-1:0] child_city;
        logic              slot_filled;
        logic              last_city;
    } t_out_item;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_PLACE,
        ST_EMIT
    } t_state;

    // A cut past the end of the tour saturates to the last position.
    function automatic logic [POS_W-1:0] sat_cut(input logic [CITY_W-1:0] cut);
        logic [POS_W-1:0] res;
        if (int'(cut) > TOUR_LENGTH - 1) begin
            res = LAST_POS;
        end else begin
            res = POS_W'(int'(cut));
        end
        return res;
    endfunction

    // Step a position forward, wrapping at the end of the tour.
    function automatic logic [POS_W-1:0] next_pos(input logic [POS_W-1:0] pos);
        logic [POS_W-1:0] res;
        if (pos == LAST_POS) begin
            res = FIRST_POS;
        end else begin
            res = pos + POS_W'(1);
        end
        return res;
    endfunction

endpackage

FILE: rtl/one_point_order_crossover_core.sv
// One-point order crossover for tours of opoc_pkg::TOUR_LENGTH cities. A tour
// set arrives as TOUR_LENGTH input transactions, one position of both parents
// each, one per cycle; the cut point is taken from the first transaction of
// the set and saturates to the last position. After the last position is
// loaded the block places parent 2 cities: one shared compare unit tests
// one parent 2 city per cycle against all filled child positions at once.
// It then delivers TOUR_LENGTH output transactions, one per cycle when the
// sink is ready, the last one flagged by last_city. The placement scan and
// the emit pass bound the throughput, since no new set is loaded until the
// previous one has been placed and emitted. The input side is not ready
// during placement and emission; a new set may start loading while the
// final child transaction still waits.
module one_point_order_crossover_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  opoc_pkg::t_in_item  i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output opoc_pkg::t_out_item o_data
);
    import opoc_pkg::*;

    // Sequencer and position registers.
    t_state                  r_state, n_state;
    logic [POS_W-1:0]        r_load_pos;
    logic [POS_W-1:0]        r_cut;
    logic [POS_W-1:0]        r_place_pos;
    logic [POS_W-1:0]        r_scan_pos;
    logic [POS_W-1:0]        r_emit_pos;
    logic [TOUR_LENGTH-1:0]  r_filled;

    // Child and parent 2 storage, no reset needed.
    logic [CITY_W-1:0]       r_child  [TOUR_LENGTH];
    logic [CITY_W-1:0]       r_parent2[TOUR_LENGTH];

    // Output register.
    logic                    r_out_valid;
    t_out_item               r_out;

    logic                    in_fire;
    logic                    place_en;
    logic                    emit_en;
    logic [POS_W-1:0]        eff_cut;
    logic [CITY_W-1:0]       scan_city;
    logic                    city_present;

    assign in_fire = i_valid && o_ready;
    assign eff_cut = (r_load_pos == FIRST_POS) ? sat_cut(i_data.cut_point) : r_cut;

    // Shared membership compare against every filled child position.
    assign scan_city = r_parent2[r_scan_pos];
    always_comb begin
        city_present = 1'b0;
        for (int j = 0; j < TOUR_LENGTH; j++) begin
            if (r_filled[j] && (r_child[j] == scan_city)) begin
                city_present = 1'b1;
            end
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (in_fire && (r_load_pos == LAST_POS)) begin
                    n_state = ST_PLACE;
                end
            end
            ST_PLACE: begin
                if (r_scan_pos == LAST_POS) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit_en && (r_emit_pos == LAST_POS)) begin
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // State outputs.
    always_comb begin
        o_ready  = 1'b0;
        place_en = 1'b0;
        emit_en  = 1'b0;
        unique case (r_state)
            ST_LOAD: begin
                o_ready = 1'b1;
            end
            ST_PLACE: begin
                place_en = 1'b1;
            end
            ST_EMIT: begin
                emit_en = !r_out_valid || i_ready;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_load_pos  <= FIRST_POS;
            r_cut       <= FIRST_POS;
            r_place_pos <= FIRST_POS;
            r_scan_pos  <= FIRST_POS;
            r_emit_pos  <= FIRST_POS;
            r_filled    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            // Loading one position per transaction.
            if (in_fire) begin
                r_cut      <= eff_cut;
                r_load_pos <= next_pos(r_load_pos);
                if (r_load_pos == FIRST_POS) begin
                    r_filled <= TOUR_LENGTH'(1);
                end else if (r_load_pos <= eff_cut) begin
                    r_filled[r_load_pos] <= 1'b1;
                end
                if (r_load_pos == LAST_POS) begin
                    r_place_pos <= next_pos(r_cut);
                    r_scan_pos  <= FIRST_POS;
                end
            end

            // Placement scan over parent 2.
            if (place_en) begin
                r_scan_pos <= next_pos(r_scan_pos);
                if (!city_present) begin
                    r_filled[r_place_pos] <= 1'b1;
                    r_place_pos           <= next_pos(r_place_pos);
                end
                if (r_scan_pos == LAST_POS) begin
                    r_emit_pos <= FIRST_POS;
                end
            end

            // Emit pass.
            if (emit_en) begin
                r_emit_pos <= next_pos(r_emit_pos);
            end
            if (emit_en) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Storage and output payload.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_parent2[r_load_pos] <= i_data.parent2_city;
            if (r_load_pos <= eff_cut) begin
                r_child[r_load_pos] <= i_data.parent1_city;
            end else begin
                r_child[r_load_pos] <= '0;
            end
        end else if (place_en && !city_present) begin
            r_child[r_place_pos] <= scan_city;
        end
        if (emit_en) begin
            r_out.child_city  <= r_filled[r_emit_pos] ? r_child[r_emit_pos] : '0;
            r_out.slot_filled <= r_filled[r_emit_pos];
            r_out.last_city   <= (r_emit_pos == LAST_POS);
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // The last loaded position starts the placement scan.
    a_load_to_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && (r_load_pos == LAST_POS)) |=> (r_state == ST_PLACE))
        else $error("placement did not start after the last position");

    // No transaction is taken while placing or emitting.
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_PLACE) || (r_state == ST_EMIT)) |-> !o_ready)
        else $error("input ready while the child is being built");

    // A finished scan starts emission at the first position.
    a_place_to_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_PLACE) && (r_scan_pos == LAST_POS))
        |=> ((r_state == ST_EMIT) && (r_emit_pos == FIRST_POS)))
        else $error("emission did not start at the first position");

    // Leaving the emit pass loads the final position into the output register.
    a_emit_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_EMIT) && emit_en && (r_emit_pos == LAST_POS))
        |=> (o_valid && o_data.last_city && (r_state == ST_LOAD)))
        else $error("final child transaction not flagged");

endmodule

FILE: tb/one_point_order_crossover_core_test.sv
module one_point_order_crossover_core_test;

    import opoc_pkg::*;

    // A whole parent tour, one city per position.
    typedef logic [TOUR_LENGTH-1:0][CITY_W-1:0] t_tour;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    t_in_item   i_data;
    logic       o_valid;
    logic       i_ready;
    t_out_item  o_data;

    // Expected child positions, oldest first.
    t_out_item child_expected[$];

    // Crossover state as the block should hold it.
    logic [CITY_W-1:0]      pred_child[TOUR_LENGTH];
    logic [CITY_W-1:0]      pred_parent2[TOUR_LENGTH];
    logic [TOUR_LENGTH-1:0] pred_filled;
    int                     pred_load_pos;
    int                     pred_cut;

    // Run bookkeeping.
    int                     error_count;
    int                     tours_loaded;
    int                     positions_sent;
    int                     positions_checked;
    logic [TOUR_LENGTH-1:0] cuts_seen;
    bit                     steady_flow;
    int                     sink_stall;

    one_point_order_crossover_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    // Clock generation.
    always #5 i_clk = ~i_clk;

    // Idle length: mostly none or short, now and then long. None in steady stretches.
    function automatic int idle_cycles();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (steady_flow || r < 50) begin
            n = 0;
        end else if (r < 85) begin
            n = $urandom_range(1, 2);
        end else if (r < 97) begin
            n = $urandom_range(3, 6);
        end else begin
            n = $urandom_range(10, 30);
        end
        return n;
    endfunction

    // Print one line per mismatch, but keep the log short on a bad run.
    task automatic report_mismatch(input string msg);
        if (error_count < 40) begin
            $display("[%0t] MISMATCH: %s", $time, msg);
        end
        error_count++;
    endtask

    // Update the predicted state with one loaded position; a full tour
    // produces the whole child.
    task automatic absorb_position(input t_in_item item);
        int        pos;
        int        slot;
        logic      present;
        t_out_item res;
        pos = pred_load_pos;
        if (pos == 0) begin
            pred_cut = (int'(item.cut_point) > TOUR_LENGTH - 1) ? TOUR_LENGTH - 1
                                                                 : int'(item.cut_point);
            pred_filled = '0;
            cuts_seen[pred_cut] = 1'b1;
        end
        if (pos <= pred_cut) begin
            pred_child[pos]  = item.parent1_city;
            pred_filled[pos] = 1'b1;
        end else begin
            pred_child[pos] = '0;
        end
        pred_parent2[pos] = item.parent2_city;

        if (pos < TOUR_LENGTH - 1) begin
            pred_load_pos = pos + 1;
        end else begin
            pred_load_pos = 0;
            tours_loaded++;
            // Place parent 2 cities that are not yet in a filled slot.
            slot = (pred_cut + 1 >= TOUR_LENGTH) ? 0 : pred_cut + 1;
            for (int i = 0; i < TOUR_LENGTH; i++) begin
                present = 1'b0;
                for (int j = 0; j < TOUR_LENGTH; j++) begin
                    if (pred_filled[j] && pred_child[j] == pred_parent2[i]) begin
                        present = 1'b1;
                    end
                end
                if (!present) begin
                    pred_child[slot]  = pred_parent2[i];
                    pred_filled[slot] = 1'b1;
                    slot = (slot == TOUR_LENGTH - 1) ? 0 : slot + 1;
                end
            end
            // The child comes out in position order.
            for (int k = 0; k < TOUR_LENGTH; k++) begin
                res.child_city  = pred_filled[k] ? pred_child[k] : '0;
                res.slot_filled = pred_filled[k];
                res.last_city   = (k == TOUR_LENGTH - 1);
                child_expected.push_back(res);
            end
        end
    endtask

    // Send one position transaction, with a random gap in front of it.
    task automatic send_position(input t_in_item item);
        int gap;
        gap = idle_cycles();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= item;
        do @(posedge i_clk); while (!o_ready);
        absorb_position(item);
        positions_sent++;
    endtask

    // Send a full tour set; only the first cut field matters to the block.
    task automatic send_tour(input t_tour p1, input t_tour p2,
                             input logic [CITY_W-1:0] cut);
        t_in_item item;
        for (int k = 0; k < TOUR_LENGTH; k++) begin
            item.parent1_city = p1[k];
            item.parent2_city = p2[k];
            item.cut_point    = (k == 0) ? cut : CITY_W'($urandom_range(0, 7));
            send_position(item);
        end
    endtask

    function automatic t_tour random_permutation();
        t_tour             t;
        int                j;
        logic [CITY_W-1:0] tmp;
        for (int k = 0; k < TOUR_LENGTH; k++) begin
            t[k] = CITY_W'(k);
        end
        for (int k = TOUR_LENGTH - 1; k > 0; k--) begin
            j    = $urandom_range(0, k);
            tmp  = t[k];
            t[k] = t[j];
            t[j] = tmp;
        end
        return t;
    endfunction

    function automatic t_tour random_cities();
        t_tour t;
        for (int k = 0; k < TOUR_LENGTH; k++) begin
            t[k] = CITY_W'($urandom_range(0, 7));
        end
        return t;
    endfunction

    // Lowest and highest cut, cities 0 and 7, and a city 0 that sits only
    // in unfilled slots and must not count as present.
    task automatic test_edge_cuts();
        t_tour p1;
        t_tour p2;
        for (int k = 0; k < TOUR_LENGTH; k++) begin
            p1[k] = CITY_W'(TOUR_LENGTH - 1 - k);
            p2[k] = '0;
        end
        send_tour(p1, p2, 3'd0);
        for (int k = 0; k < TOUR_LENGTH; k++) begin
            p1[k] = CITY_W'(k);
            p2[k] = 3'd7;
        end
        send_tour(p1, p2, 3'd7);
    endtask

    // More cities to place than free slots: placement wraps and overwrites
    // parent 1 copies.
    task automatic test_overflow_placement();
        t_tour p1;
        t_tour p2;
        for (int k = 0; k < TOUR_LENGTH; k++) begin
            p1[k] = '0;
            p2[k] = CITY_W'((k + 1) % TOUR_LENGTH);
        end
        send_tour(p1, p2, 3'd3);
    endtask

    // Well-formed parent pairs with random cuts; some stretches run without idling.
    task automatic test_random_permutations(input int tours);
        for (int n = 0; n < tours; n++) begin
            steady_flow = ($urandom_range(0, 3) == 0);
            send_tour(random_permutation(), random_permutation(),
                      CITY_W'($urandom_range(0, 7)));
        end
        steady_flow = 1'b0;
    endtask

    // Parents with repeated cities, or random noise altogether.
    task automatic test_broken_tours(input int tours);
        t_tour p1;
        t_tour p2;
        for (int n = 0; n < tours; n++) begin
            if ($urandom_range(0, 1) == 0) begin
                p1 = random_cities();
                p2 = random_cities();
            end else begin
                p1 = random_permutation();
                p2 = random_permutation();
                p1[$urandom_range(0, TOUR_LENGTH - 1)] = CITY_W'($urandom_range(0, 7));
                p2[$urandom_range(0, TOUR_LENGTH - 1)] = CITY_W'($urandom_range(0, 7));
            end
            send_tour(p1, p2, CITY_W'($urandom_range(0, 7)));
        end
    endtask

    // Let the block drain completely between two sets.
    task automatic test_drain_between_sets();
        send_tour(random_permutation(), random_permutation(),
                  CITY_W'($urandom_range(0, 7)));
        i_valid <= 1'b0;
        wait (child_expected.size() == 0);
        @(posedge i_clk);
        send_tour(random_permutation(), random_cities(), CITY_W'($urandom_range(0, 7)));
    endtask

    // Compare one child transaction with the oldest expectation.
    task automatic check_child_position(input t_out_item got);
        t_out_item want;
        if (child_expected.size() == 0) begin
            report_mismatch($sformatf("unexpected child transaction city=%0d filled=%0b last=%0b",
                                      got.child_city, got.slot_filled, got.last_city));
        end else begin
            want = child_expected.pop_front();
            if (got.child_city !== want.child_city) begin
                report_mismatch($sformatf("child_city got %0d want %0d",
                                          got.child_city, want.child_city));
            end
            if (got.slot_filled !== want.slot_filled) begin
                report_mismatch($sformatf("slot_filled got %0b want %0b",
                                          got.slot_filled, want.slot_filled));
            end
            if (got.last_city !== want.last_city) begin
                report_mismatch($sformatf("last_city got %0b want %0b",
                                          got.last_city, want.last_city));
            end
        end
        positions_checked++;
    endtask

    // Output side: check accepted transactions, then choose the next ready.
    always @(posedge i_clk) begin
        int gap;
        if (i_rst_n && o_valid && i_ready) begin
            check_child_position(o_data);
        end
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (sink_stall > 0) begin
            sink_stall = sink_stall - 1;
            i_ready <= 1'b0;
        end else begin
            gap = idle_cycles();
            if (gap == 0) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b0;
                sink_stall = gap - 1;
            end
        end
    end

    // Main sequence.
    initial begin
        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        i_valid           = 1'b0;
        i_data            = '0;
        i_ready           = 1'b0;
        error_count       = 0;
        tours_loaded      = 0;
        positions_sent    = 0;
        positions_checked = 0;
        cuts_seen         = '0;
        steady_flow       = 1'b0;
        sink_stall        = 0;
        pred_load_pos     = 0;
        pred_cut          = 0;
        pred_filled       = '0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_edge_cuts();
        test_overflow_placement();
        test_random_permutations(26);
        test_broken_tours(6);
        test_drain_between_sets();

        i_valid <= 1'b0;
        wait (child_expected.size() == 0);
        repeat (4 * TOUR_LENGTH) @(posedge i_clk);

        $display("Covered %0d tour sets from %0d input transactions; %0d child positions checked.",
                 tours_loaded, positions_sent, positions_checked);
        $display("Cut values used (bit per cut): %b", cuts_seen);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #3000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
